// ===== design/psfd_pkg.sv =====
// Package: shared types and constants for the PPM sum frame decoder.
`timescale 1ns / 1ps

package psfd_pkg;

  // Channel slots and index sizing
  localparam int NUM_CHANNELS = 8;
  localparam int IDX_W        = $clog2(NUM_CHANNELS + 1);
  localparam int CH_W         = 3;
  localparam int TIME_W       = 16;
  localparam int VAL_W        = 15;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_PPM_MODE  = 3'd0,
    REG_SYNC_GAP      = 3'd1,
    REG_PULSE_MIN     = 3'd2,
    REG_PULSE_MAX     = 3'd3,
    REG_PWM_TARGET    = 3'd4
  } reg_idx_t;

  // Reset values of the registers
  localparam logic              RST_USE_PPM_MODE = 1'b1;
  localparam logic [TIME_W-1:0] RST_SYNC_GAP     = 16'd8000;
  localparam logic [TIME_W-1:0] RST_PULSE_MIN    = 16'd1500;
  localparam logic [TIME_W-1:0] RST_PULSE_MAX    = 16'd4500;
  localparam logic [CH_W-1:0]   RST_PWM_TARGET   = 3'd1;

  typedef struct packed {
    logic              use_ppm_mode;
    logic [TIME_W-1:0] sync_gap_threshold;
    logic [TIME_W-1:0] pulse_min_exclusive;
    logic [TIME_W-1:0] pulse_max_exclusive;
    logic [CH_W-1:0]   pwm_target_channel;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] previous_capture;
    logic [IDX_W-1:0]  channel_index;
    logic [TIME_W-1:0] rise_capture;
    logic              awaiting_fall;
  } state_t;

  typedef struct packed {
    logic             value_written;
    logic [CH_W-1:0]  channel_number;
    logic [VAL_W-1:0] channel_value;
    logic             frame_sync;
    logic             arm_falling_edge;
  } result_t;

  // Interval between two captures; a non-increasing pair counts as a wrap
  // that loses one tick, so equal captures give all ones.
  function automatic logic [TIME_W-1:0] span16(input logic [TIME_W-1:0] from,
                                               input logic [TIME_W-1:0] to);
    logic [TIME_W-1:0] d;
    d = to - from;
    if (to > from) begin
      return d;
    end
    return d - TIME_W'(1);
  endfunction

endpackage

// ===== design/psfd_step.sv =====
// Combinational step: one capture against current state gives next state and a result.
`timescale 1ns / 1ps

module psfd_step (
  input  psfd_pkg::cfg_t                    cfg,
  input  psfd_pkg::state_t                  cur,
  input  logic [psfd_pkg::TIME_W-1:0]       capture_time,
  output psfd_pkg::state_t                  nxt,
  output psfd_pkg::result_t                 res
);

  logic [psfd_pkg::TIME_W-1:0] ppm_diff;
  logic [psfd_pkg::TIME_W-1:0] pwm_width;
  logic                        idx_open;
  logic                        target_ok;

  assign ppm_diff  = psfd_pkg::span16(cur.previous_capture, capture_time);
  assign pwm_width = psfd_pkg::span16(cur.rise_capture, capture_time);
  assign idx_open  = int'(cur.channel_index) < psfd_pkg::NUM_CHANNELS;
  assign target_ok = int'(cfg.pwm_target_channel) < psfd_pkg::NUM_CHANNELS;

  // Decode one edge in the selected mode
  always_comb begin
    nxt = cur;
    res = '0;
    nxt.previous_capture = capture_time;
    if (!cfg.use_ppm_mode) begin
      if (!cur.awaiting_fall) begin
        nxt.rise_capture  = capture_time;
        nxt.awaiting_fall = 1'b1;
      end else begin
        if (target_ok) begin
          res.value_written  = 1'b1;
          res.channel_number = cfg.pwm_target_channel;
          res.channel_value  = pwm_width[psfd_pkg::TIME_W-1:1];
        end
        nxt.awaiting_fall = 1'b0;
      end
      res.arm_falling_edge = nxt.awaiting_fall;
    end else begin
      if (ppm_diff > cfg.sync_gap_threshold) begin
        nxt.channel_index = '0;
        res.frame_sync    = 1'b1;
      end else begin
        if (ppm_diff > cfg.pulse_min_exclusive && ppm_diff < cfg.pulse_max_exclusive &&
            idx_open) begin
          res.value_written  = 1'b1;
          res.channel_number = psfd_pkg::CH_W'(cur.channel_index);
          res.channel_value  = ppm_diff[psfd_pkg::TIME_W-1:1];
        end
        // Advance, holding at the slot count
        if (idx_open) begin
          nxt.channel_index = cur.channel_index + psfd_pkg::IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== design/ppm_sum_frame_decoder.sv =====
// Top level: PPM sum / single PWM capture decoder with config port and output register.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   in       | sink      | in_valid / in_ready  | capture_time[15:0]
//   out      | source    | out_valid/out_ready  | value_written, channel_number[2:0],
//            |           |                      | channel_value[14:0], frame_sync,
//            |           |                      | arm_falling_edge
//   cfg      | sink      | cfg_valid/cfg_ready  | cfg_index[2:0], cfg_data[15:0]
//
// One beat per cycle unless the output stalls: each capture is decoded by a single
// subtract-compare stage; its result lands in the output register on the accepting edge.
// in_ready drops only while a result is held and out_ready is low.
// cfg_ready is always high; writes to unlisted indexes are dropped.
// Synchronous reset clears decoder state, registers to defaults, out_valid low.
`timescale 1ns / 1ps

module ppm_sum_frame_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psfd_pkg::TIME_W-1:0]       capture_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              value_written,
  output logic [psfd_pkg::CH_W-1:0]         channel_number,
  output logic [psfd_pkg::VAL_W-1:0]        channel_value,
  output logic                              frame_sync,
  output logic                              arm_falling_edge,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  psfd_pkg::cfg_t    cfg;
  psfd_pkg::state_t  state;
  psfd_pkg::state_t  state_next;
  psfd_pkg::result_t step_res;
  psfd_pkg::result_t result;
  logic              in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_ppm_mode        <= psfd_pkg::RST_USE_PPM_MODE;
      cfg.sync_gap_threshold  <= psfd_pkg::RST_SYNC_GAP;
      cfg.pulse_min_exclusive <= psfd_pkg::RST_PULSE_MIN;
      cfg.pulse_max_exclusive <= psfd_pkg::RST_PULSE_MAX;
      cfg.pwm_target_channel  <= psfd_pkg::RST_PWM_TARGET;
    end else if (cfg_valid && cfg_ready) begin
      case (psfd_pkg::reg_idx_t'(cfg_index))
        psfd_pkg::REG_USE_PPM_MODE: cfg.use_ppm_mode        <= cfg_data[0];
        psfd_pkg::REG_SYNC_GAP:     cfg.sync_gap_threshold  <= cfg_data;
        psfd_pkg::REG_PULSE_MIN:    cfg.pulse_min_exclusive <= cfg_data;
        psfd_pkg::REG_PULSE_MAX:    cfg.pulse_max_exclusive <= cfg_data;
        psfd_pkg::REG_PWM_TARGET:   cfg.pwm_target_channel  <= cfg_data[psfd_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  psfd_step u_step (
    .cfg          (cfg),
    .cur          (state),
    .capture_time (capture_time),
    .nxt          (state_next),
    .res          (step_res)
  );

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= step_res;
    end
  end

  assign value_written    = result.value_written;
  assign channel_number   = result.channel_number;
  assign channel_value    = result.channel_value;
  assign frame_sync       = result.frame_sync;
  assign arm_falling_edge = result.arm_falling_edge;

endmodule

// ===== design/psfd_checker.sv =====
// Checker: port-level assertions for the decoder, bound to the top level.
`timescale 1ns / 1ps

module psfd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              value_written,
  input logic [psfd_pkg::CH_W-1:0]         channel_number,
  input logic [psfd_pkg::VAL_W-1:0]        channel_value,
  input logic                              frame_sync,
  input logic                              arm_falling_edge
);

  // A beat that stored nothing carries a zero slot and value
  a_idle_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !value_written |-> channel_number == '0 && channel_value == '0)
    else $error("result without a write carries slot or value");

  // A frame sync never stores a slot and never arms a fall
  a_sync_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_sync |-> !value_written && !arm_falling_edge)
    else $error("frame sync combined with write or fall arm");

  // An accepted capture yields a result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted capture produced no result");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_written) &&
      $stable(channel_number) && $stable(channel_value) && $stable(frame_sync) &&
      $stable(arm_falling_edge))
    else $error("stalled result changed");

endmodule

bind ppm_sum_frame_decoder psfd_checker u_psfd_checker (.*);
